@@ sv/mcs_pkg.sv @@
// Shared types, widths and helper functions for the monotone cubic slope block.
`default_nettype none
package mcs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Fixed datapath widths
  localparam int unsigned IDX_W = 10;   // point index field
  localparam int unsigned QUO_W = 41;   // divider quotient bits, top bit flags overflow
  localparam int unsigned NUM_W = 98;   // widest dividend
  localparam int unsigned DEN_W = 66;   // widest divisor
  localparam int unsigned ACC_W = 100;  // signed accumulator
  localparam int unsigned MA_W  = 35;   // multiplier operand a
  localparam int unsigned MB_W  = 32;   // multiplier operand b (one limb)

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_ASC = 2'd1,
    ST_FEW     = 2'd2,
    ST_MANY    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] abscissa;
    logic signed [31:0] ordinate;
    logic               final_point;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   point_index;
    logic signed [31:0] slope;
    logic               run_end;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            issue;
    logic            clear;
    logic            sub;
    logic            sh;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mac_req_t;

  // Magnitude of a signed 32-bit value (2^31 fits unsigned)
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  // Apply a sign to a quotient magnitude and saturate to 32 bits
  function automatic logic signed [31:0] sat_mag(input logic [QUO_W-1:0] q, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > QUO_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      r = (q > QUO_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : $signed(32'(-q[31:0]));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/mcs_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all slope steps.
`default_nettype none
module mcs_div import mcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned DW = DEN_W + QUO_W - 1;
  localparam int unsigned CW = $clog2(QUO_W);

  logic [DW-1:0]    rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic             ge;

  assign ge = rem_q >= dsh_q;

  // Control: step count and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUO_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  // Datapath: compare against the shifted divisor, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DW'(req_i.num);
      dsh_q <= DW'(req_i.den) << (QUO_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - dsh_q : rem_q;
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

@@ sv/mcs_mac.sv @@
// Shared multiply-accumulate unit: registered product, then signed accumulate.
`default_nettype none
module mcs_mac import mcs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic [MA_W+MB_W-1:0]    prod_q;
  logic                    vld_q, clr_q, sub_q, sh_q;
  logic signed [ACC_W-1:0] acc_q, base, term;

  // Operation tags travel with the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      clr_q <= 1'b0;
      sub_q <= 1'b0;
      sh_q  <= 1'b0;
    end else begin
      vld_q <= req_i.issue;
      clr_q <= req_i.clear;
      sub_q <= req_i.sub;
      sh_q  <= req_i.sh;
    end
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    if (req_i.issue) begin
      prod_q <= (MA_W+MB_W)'(req_i.a) * (MA_W+MB_W)'(req_i.b);
    end
  end

  // Accumulate stage, upper limb shifted by one operand width
  always_comb begin
    base = clr_q ? '0 : acc_q;
    term = sh_q ? $signed(ACC_W'(prod_q) << MB_W) : $signed(ACC_W'(prod_q));
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      acc_q <= sub_q ? base - term : base + term;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

@@ sv/monotone_cubic_slopes.sv @@
// Top level: streamed Fritsch-Carlson monotone cubic slopes over fixed-point points.
//
// Points enter on the in channel (valid/ready), one request per point, with
// final_point set on the last one. Slopes leave on the out channel in point
// order, each with its index, run_end on the last one and a status code.
// The block takes one point at a time and holds in_ready_o low while it works.
// Every later point that ascends runs a secant division; an end slope of three or
// more points, and an interior slope whose secants share a sign, then take
// multiply-accumulate steps and a second division on the same shared divider.
// The third and the final point also close an end. Errors give one result with
// status set and the rest of the sequence is dropped up to its final point.
// The last result waits in an output register, so the next point can be taken
// while the receiver stalls; further results wait for that register to drain.
// Reset clears the sequence state and empties the output register.
`default_nettype none
module monotone_cubic_slopes import mcs_pkg::*; #(
  parameter int unsigned MAX_POINTS    = MAX_POINTS_DEF,
  parameter int unsigned FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW = CW + IDX_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SEC  = 5'b00010,
    S_MAC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    J_E0  = 2'd0,
    J_INT = 2'd1,
    J_EF  = 2'd2
  } job_e;

  typedef struct packed {
    logic two0;
    logic two1;
    logic e0;
    logic mid;
    logic ef;
  } pend_t;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  pend_t  pend_q, pend_d, pend_new, pend_src;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic          disc_q, disc_d, upd_q, upd_d, fin_q, fin_d;
  logic          dyneg_q, dyneg_d, eneg_q, eneg_d;
  logic          out_valid_q, out_valid_d;
  logic [3:0]    st_q, st_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, psec_q, psec_d, d_q, d_d;
  logic [31:0]        pstep_q, pstep_d, h_q, h_d;
  logic [63:0]        p_q, p_d;
  logic [DEN_W-1:0]   den_q, den_d;
  out_t res_q, res_d, out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_req_t mac_req;
  logic signed [ACC_W-1:0] acc;

  // Shared arithmetic units
  mcs_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  mcs_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mac_req),
    .acc_o (acc)
  );

  // Input side arithmetic
  logic        in_fire, fin;
  logic [32:0] dx, dy, mdy;
  logic        x_gt;
  assign in_fire = in_valid_i && in_ready_o;
  assign fin     = in_data_i.final_point;
  assign dx      = {in_data_i.abscissa[31], in_data_i.abscissa} - {px_q[31], px_q};
  assign dy      = {in_data_i.ordinate[31], in_data_i.ordinate} - {py_q[31], py_q};
  assign mdy     = dy[32] ? 33'(-dy) : dy;
  assign x_gt    = in_data_i.abscissa > px_q;

  // Index views
  logic [EW-1:0]    cnt_ext, idx_ext, idxm1_ext;
  logic [IDX_W-1:0] cnt10, idx10, idxm1_10;
  assign cnt_ext   = EW'(cnt_q);
  assign idx_ext   = EW'(idx_q);
  assign idxm1_ext = EW'(idx_q - CW'(1));
  assign cnt10     = cnt_ext[IDX_W-1:0];
  assign idx10     = idx_ext[IDX_W-1:0];
  assign idxm1_10  = idxm1_ext[IDX_W-1:0];

  // Secant from the divider, and the secant in force
  logic signed [31:0] sec_d, dsel;
  assign sec_d = sat_mag(div_rsp.quo, dyneg_q);
  assign dsel  = (state_q == S_SEC) ? sec_d : d_q;

  function automatic logic same_sign(input logic signed [31:0] a, input logic signed [31:0] b);
    return (a != '0) && (b != '0) && (a[31] == b[31]);
  endfunction

  // Operands of the current slope job
  logic [31:0]        hn, hf, mdn, mdf;
  logic signed [31:0] dn, df;
  logic [MA_W-1:0]    a_end, w1, s3;
  logic [32:0]        hsum;
  always_comb begin
    case (job_q)
      J_E0: begin
        hn = pstep_q; hf = h_q; dn = psec_q; df = d_q;
      end
      J_EF: begin
        hn = h_q; hf = pstep_q; dn = d_q; df = psec_q;
      end
      default: begin
        hn = pstep_q; hf = h_q; dn = psec_q; df = d_q;
      end
    endcase
  end
  assign mdn   = mag32(dn);
  assign mdf   = mag32(df);
  assign a_end = (MA_W'(hn) << 1) + MA_W'(hf);   // also w2 of an interior point
  assign w1    = (MA_W'(hf) << 1) + MA_W'(hn);
  assign s3    = w1 + a_end;
  assign hsum  = 33'(hn) + 33'(hf);

  // Final slope of a job from the divider quotient
  logic [33:0]        m3;
  logic               vss, dss, big;
  logic signed [31:0] job_slope;
  out_t               job_res;
  always_comb begin
    m3  = (34'(mdn) << 1) + 34'(mdn);
    vss = (div_rsp.quo != '0) && (dn != '0) && (eneg_q == dn[31]);
    dss = same_sign(dn, df);
    big = div_rsp.quo > QUO_W'(m3);
    if (job_q == J_INT) begin
      job_slope = sat_mag(div_rsp.quo, dn[31]);
    end else if (!vss) begin
      job_slope = '0;
    end else if (!dss && big) begin
      job_slope = sat_mag(QUO_W'(m3), dn[31]);
    end else begin
      job_slope = sat_mag(div_rsp.quo, eneg_q);
    end
    job_res.slope  = job_slope;
    job_res.status = ST_OK;
    case (job_q)
      J_E0: begin
        job_res.point_index = '0;
        job_res.run_end     = 1'b0;
      end
      J_EF: begin
        job_res.point_index = idx10;
        job_res.run_end     = 1'b1;
      end
      default: begin
        job_res.point_index = idxm1_10;
        job_res.run_end     = 1'b0;
      end
    endcase
  end

  // Pick the next result to produce
  state_e dp_state;
  job_e   dp_job;
  pend_t  dp_pend;
  out_t   dp_res;
  logic   dp_none;
  assign pend_new = '{
    two0: (idx_q == CW'(1)) && fin_q,
    two1: (idx_q == CW'(1)) && fin_q,
    e0:   idx_q == CW'(2),
    mid:  idx_q >= CW'(2),
    ef:   (idx_q >= CW'(2)) && fin_q
  };
  assign pend_src = (state_q == S_SEC) ? pend_new : pend_q;

  always_comb begin
    dp_pend  = pend_src;
    dp_res   = res_q;
    dp_job   = job_q;
    dp_state = S_MAC;
    dp_none  = 1'b0;
    if (pend_src.two0) begin
      dp_pend.two0 = 1'b0;
      dp_res       = '{point_index: '0, slope: dsel, run_end: 1'b0, status: ST_OK};
      dp_state     = S_EMIT;
    end else if (pend_src.two1) begin
      dp_pend.two1 = 1'b0;
      dp_res       = '{point_index: IDX_W'(1), slope: dsel, run_end: 1'b1, status: ST_OK};
      dp_state     = S_EMIT;
    end else if (pend_src.e0) begin
      dp_pend.e0 = 1'b0;
      dp_job     = J_E0;
    end else if (pend_src.mid) begin
      dp_pend.mid = 1'b0;
      dp_job      = J_INT;
      if (!same_sign(psec_q, dsel)) begin
        // secants differ in sign or one is zero: flat
        dp_res   = '{point_index: idxm1_10, slope: '0, run_end: 1'b0, status: ST_OK};
        dp_state = S_EMIT;
      end
    end else if (pend_src.ef) begin
      dp_pend.ef = 1'b0;
      dp_job     = J_EF;
    end else begin
      dp_none  = 1'b1;
      dp_state = S_IDLE;
    end
  end

  // Sequencer
  logic               out_load;
  logic [ACC_W-1:0]   acc_mag;
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;  job_d   = job_q;   pend_d  = pend_q;
    cnt_d   = cnt_q;    idx_d   = idx_q;   disc_d  = disc_q;
    upd_d   = upd_q;    fin_d   = fin_q;   dyneg_d = dyneg_q;
    eneg_d  = eneg_q;   st_d    = st_q;    px_d    = px_q;
    py_d    = py_q;     psec_d  = psec_q;  d_d     = d_q;
    pstep_d = pstep_q;  h_d     = h_q;     p_d     = p_q;
    den_d   = den_q;    res_d   = res_q;
    div_req = '0;
    mac_req = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (disc_q) begin
            if (fin) begin
              disc_d = 1'b0;
              cnt_d  = '0;
            end
          end else if (cnt_q >= CW'(MAX_POINTS)) begin
            res_d   = '{point_index: cnt10, slope: '0, run_end: 1'b1, status: ST_MANY};
            cnt_d   = '0;
            disc_d  = !fin;
            upd_d   = 1'b0;
            pend_d  = '0;
            state_d = S_EMIT;
          end else if (cnt_q == '0) begin
            if (fin) begin
              res_d   = '{point_index: '0, slope: '0, run_end: 1'b1, status: ST_FEW};
              upd_d   = 1'b0;
              pend_d  = '0;
              state_d = S_EMIT;
            end else begin
              px_d  = in_data_i.abscissa;
              py_d  = in_data_i.ordinate;
              cnt_d = CW'(1);
            end
          end else if (!x_gt) begin
            res_d   = '{point_index: cnt10, slope: '0, run_end: 1'b1, status: ST_NOT_ASC};
            cnt_d   = '0;
            disc_d  = !fin;
            upd_d   = 1'b0;
            pend_d  = '0;
            state_d = S_EMIT;
          end else begin
            // secant division: (|dy| << FRACTION_BITS) / dx
            h_d           = dx[31:0];
            dyneg_d       = dy[32];
            idx_d         = cnt_q;
            fin_d         = fin;
            px_d          = in_data_i.abscissa;
            py_d          = in_data_i.ordinate;
            cnt_d         = fin ? '0 : cnt_q + CW'(1);
            upd_d         = 1'b1;
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(mdy) << FRACTION_BITS;
            div_req.den   = DEN_W'(dx[31:0]);
            state_d       = S_SEC;
          end
        end
      end

      S_SEC: begin
        if (div_rsp.done) begin
          d_d     = sec_d;
          state_d = dp_state;
          job_d   = dp_job;
          pend_d  = dp_pend;
          res_d   = dp_res;
          st_d    = '0;
        end
      end

      S_MAC: begin
        st_d = st_q + 4'd1;
        if (job_q == J_INT) begin
          // num = 3(h0+h1) * m0*m1, den = w1*m1 + w2*m0
          case (st_q)
            4'd0: mac_req = '{issue: 1'b1, clear: 1'b1, sub: 1'b0, sh: 1'b0,
                              a: MA_W'(mdn), b: mdf};
            4'd2: begin
              p_d     = acc[63:0];
              mac_req = '{issue: 1'b1, clear: 1'b1, sub: 1'b0, sh: 1'b0, a: w1, b: mdf};
            end
            4'd3: mac_req = '{issue: 1'b1, clear: 1'b0, sub: 1'b0, sh: 1'b0,
                              a: a_end, b: mdn};
            4'd5: begin
              den_d   = acc[DEN_W-1:0];
              mac_req = '{issue: 1'b1, clear: 1'b1, sub: 1'b0, sh: 1'b0,
                          a: s3, b: p_q[31:0]};
            end
            4'd6: mac_req = '{issue: 1'b1, clear: 1'b0, sub: 1'b0, sh: 1'b1,
                              a: s3, b: p_q[63:32]};
            4'd8: begin
              div_req.start = 1'b1;
              div_req.num   = acc[NUM_W-1:0];
              div_req.den   = den_q;
              state_d       = S_DIV;
            end
            default: ;
          endcase
        end else begin
          // end point: ((2hn+hf)dn - hn*df) / (hn+hf), signs folded in
          case (st_q)
            4'd0: mac_req = '{issue: 1'b1, clear: 1'b1, sub: dn[31], sh: 1'b0,
                              a: a_end, b: mdn};
            4'd1: mac_req = '{issue: 1'b1, clear: 1'b0, sub: !df[31], sh: 1'b0,
                              a: MA_W'(hn), b: mdf};
            4'd3: begin
              eneg_d        = acc[ACC_W-1];
              div_req.start = 1'b1;
              div_req.num   = acc_mag[NUM_W-1:0];
              div_req.den   = DEN_W'(hsum);
              state_d       = S_DIV;
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = job_res;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = dp_state;
          job_d   = dp_job;
          pend_d  = dp_pend;
          res_d   = dp_res;
          st_d    = '0;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Point done: this point's step and secant become the previous ones
    if (((state_q == S_SEC && div_rsp.done) || out_load) && dp_none && upd_q) begin
      pstep_d = h_q;
      psec_d  = dsel;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_E0;
      pend_q      <= '0;
      cnt_q       <= '0;
      disc_q      <= 1'b0;
      upd_q       <= 1'b0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      pstep_q     <= '0;
      psec_q      <= '0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      disc_q      <= disc_d;
      upd_q       <= upd_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pstep_q     <= pstep_d;
      psec_q      <= psec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    fin_q   <= fin_d;
    dyneg_q <= dyneg_d;
    eneg_q  <= eneg_d;
    d_q     <= d_d;
    h_q     <= h_d;
    p_q     <= p_d;
    den_q   <= den_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // While a sequence is being dropped no point count builds up
  a_disc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> cnt_q == '0)
    else $error("point count nonzero while dropping a sequence");

  // The divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_SEC || state_q == S_DIV))
    else $error("divider result arrived outside a wait state");

  // A new point is never taken while a division is in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !in_ready_o)
    else $error("input ready during a division");

endmodule
`default_nettype wire

@@ test/mcs_checker.sv @@
// Checker for the monotone cubic slope block: predicts slopes and compares results.
`default_nettype none
module mcs_checker import mcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned MAXP = MAX_POINTS_DEF;
  localparam int unsigned FB   = FRAC_BITS_DEF;

  // sequence state
  logic signed [31:0] last_x, last_y, last_secant;
  logic [31:0]        last_step;
  int unsigned        seen;
  logic               skipping;
  out_t               slope_queue[$];

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic bit same_sign(input logic signed [127:0] a, input logic signed [127:0] b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  // signed division truncated toward zero, exact at 128 bits
  function automatic logic signed [127:0] div_tz(input logic signed [127:0] n,
                                                  input logic signed [127:0] d);
    logic [127:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] calc_secant(input logic signed [127:0] dy,
                                                     input logic signed [127:0] h);
    return sat32(div_tz(dy <<< FB, h));
  endfunction

  function automatic logic signed [127:0] interior_slope(
      input logic signed [127:0] h0, input logic signed [127:0] d0,
      input logic signed [127:0] h1, input logic signed [127:0] d1);
    logic signed [127:0] w1, w2;
    w1 = 2 * h1 + h0;
    w2 = h1 + 2 * h0;
    if (!same_sign(d0, d1)) return 0;
    return div_tz((w1 + w2) * d0 * d1, w1 * d1 + w2 * d0);
  endfunction

  function automatic logic signed [127:0] end_slope(
      input logic signed [127:0] hn, input logic signed [127:0] hf,
      input logic signed [127:0] dn, input logic signed [127:0] df);
    logic signed [127:0] v, an;
    v = div_tz((2 * hn + hf) * dn - hn * df, hn + hf);
    an = dn < 0 ? -dn : dn;
    if (!same_sign(v, dn)) return 0;
    if (!same_sign(dn, df) && (v < 0 ? -v : v) > 3 * an) return 3 * dn;
    return v;
  endfunction

  function automatic out_t mk(input int unsigned idx, input logic signed [127:0] s,
                              input logic fin, input status_e st);
    out_t r;
    r.point_index = idx[IDX_W-1:0];
    r.slope = sat32(s);
    r.run_end = fin;
    r.status = st;
    return r;
  endfunction

  // append one expected result at the tail
  task automatic queue_slope(input out_t r);
    slope_queue.insert(slope_queue.size(), r);
  endtask

  task automatic raise_error(input int unsigned idx, input status_e st, input logic fin);
    queue_slope(mk(idx, 0, 1'b1, st));
    seen = 0;
    skipping = !fin;
  endtask

  // predict results of one accepted point
  task automatic predict_point(input in_t p);
    logic signed [127:0] h, d, hp, dp;
    if (skipping) begin
      if (p.final_point) begin
        skipping = 0;
        seen = 0;
      end
    end else if (seen >= MAXP) begin
      raise_error(seen, ST_MANY, p.final_point);
    end else if (seen == 0) begin
      if (p.final_point) raise_error(0, ST_FEW, 1'b1);
      else begin
        last_x = p.abscissa;
        last_y = p.ordinate;
        seen = 1;
      end
    end else if (!(p.abscissa > last_x)) begin
      raise_error(seen, ST_NOT_ASC, p.final_point);
    end else begin
      h = 128'(p.abscissa) - 128'(last_x);
      d = calc_secant(128'(p.ordinate) - 128'(last_y), h);
      if (seen == 1) begin
        if (p.final_point) begin
          queue_slope(mk(0, d, 1'b0, ST_OK));
          queue_slope(mk(1, d, 1'b1, ST_OK));
        end
      end else begin
        hp = {96'd0, last_step};
        dp = last_secant;
        if (seen == 2) queue_slope(mk(0, end_slope(hp, h, dp, d), 1'b0, ST_OK));
        queue_slope(mk(seen - 1, interior_slope(hp, dp, h, d), 1'b0, ST_OK));
        if (p.final_point) queue_slope(mk(seen, end_slope(h, hp, d, dp), 1'b1, ST_OK));
      end
      last_x = p.abscissa;
      last_y = p.ordinate;
      last_step = h[31:0];
      last_secant = d[31:0];
      seen = p.final_point ? 0 : seen + 1;
    end
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      last_x = 0; last_y = 0; last_step = 0; last_secant = 0;
      seen = 0; skipping = 0;
      slope_queue.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (slope_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = slope_queue.pop_front();
          if (want.point_index !== out_data_i.point_index || want.slope !== out_data_i.slope ||
              want.run_end !== out_data_i.run_end || want.status !== out_data_i.status) begin
            $display("%0t: expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_point(in_data_i);
      pending_o <= slope_queue.size();
    end
  end

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench top: drives point requests into the slope block and gives the verdict.
`default_nettype none
module testbench;
  import mcs_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_t  in_data = '0;
  out_t out_data;
  int unsigned fail_count, pending;
  bit   hold_off = 0;

  always #6 clk_i = ~clk_i;

  monotone_cubic_slopes u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  mcs_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) out_ready <= 0;
    else case ($urandom_range(0, 3))
      0: out_ready <= 0;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= 1;
    endcase
  end

  // send one point; random gap before it when a burst has ended
  int burst_left = 0;
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 300);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    in_data <= '{abscissa: x, ordinate: y, final_point: fin};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand32();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom());
    endcase
  endfunction

  // well-formed ascending sequence with random content
  task automatic send_run(input int n);
    logic signed [63:0] x;
    logic signed [31:0] y;
    int stepmax;
    stepmax = $urandom_range(0, 2) == 0 ? 32'h7FFF_FFFF / (n + 1) : 32'h4_0000;
    x = $signed(64'($urandom_range(0, 32'h10_0000))) - 64'sh8_0000;
    if ($urandom_range(0, 4) == 0) x = -64'sh8000_0000;
    for (int i = 0; i < n; i++) begin
      y = $urandom_range(0, 3) == 0 ? rand32()
                                    : $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      send_point(x[31:0], y, i == n - 1);
      x = x + 1 + $urandom_range(0, stepmax);
      if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: two points, too few, not ascending, extremes, sign change, wide step
    send_point(32'sh8000_0000, 32'sh8000_0000, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_point(0, 5, 1);
    send_point(0, 0, 0);
    send_point(1, 32'sh7FFF_FFFF, 0);
    send_point(2, 32'sh8000_0000, 1);
    send_point(100, 1, 0);
    send_point(100, 2, 0);
    send_point(200, 3, 1);
    send_point(10, 0, 0);
    send_point(20, 100, 0);
    send_point(30, 50, 0);
    send_point(40, 50, 0);
    send_point(50, 60, 1);
    send_point(0, 0, 0);
    send_point(65536, 0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    // long hold-off while points keep coming
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      send_run(30);
    join
    // too many points: one sequence past the limit, then its tail discarded
    for (int i = 0; i < MAX_POINTS_DEF + 2; i++)
      send_point(i * 8, $signed($urandom_range(0, 4000)), i == MAX_POINTS_DEF + 1);
    // random part
    for (int k = 0; k < 60; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_point(rand32(), rand32(), $urandom_range(0, 1));
      end else send_run($urandom_range(2, 8));
    end
    in_valid <= 0;
    // drain
    @(posedge clk_i);
    fork : drain
      wait (pending == 0);
      repeat (200000) @(posedge clk_i);
    join_any
    disable drain;
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
